>>> rtl/frtr_pkg.sv
// Shared constants, codes and control structs for the fetch request tracker.
package frtr_pkg;

  // Default widths of the kernel id and address fields.
  localparam int KERNEL_ID_BITS_DEFAULT = 8;
  localparam int ADDR_BITS_DEFAULT      = 32;

  // Bin storage.
  localparam int SLOT_COUNT = 3;
  localparam int SLOT_BITS  = 2;
  localparam int TIMER_BITS = 16;
  localparam int SERVER_BITS = 32;

  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [TIMER_BITS-1:0]  timer_t;
  typedef logic [SERVER_BITS-1:0] server_t;

  // Configuration register indexes.
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_SERVER_ADDRESS = 1'b0;
  localparam cfg_index_t CFG_TIMEOUT_RELOAD = 1'b1;

  // Configuration reset values.
  localparam server_t SERVER_RESET  = '0;
  localparam timer_t  TIMEOUT_RESET = 16'd1024;

  // Update commands for the bin store.
  typedef struct packed {
    logic  free;       // release a bin after a matching response
    slot_t free_slot;
    logic  load;       // take a new request into a bin
    slot_t load_slot;
    logic  retry;      // reload the timer of a bin that is sent again
    slot_t retry_slot;
    logic  tick;       // count down all running timers
  } bin_cmd_t;

  // Status of the bin store seen by the control logic.
  typedef struct packed {
    logic  match_hit;   // a busy bin holds the response kernel id
    slot_t match_slot;  // first such bin
    logic  expire_hit;  // a busy bin has its timer at zero
    slot_t expire_slot; // first such bin
  } bin_status_t;

endpackage

>>> rtl/frtr_bins.sv
// Bin store: busy flags, kernel ids and retry timers of the three fetch bins.
module frtr_bins #(
  parameter int KERNEL_ID_BITS = frtr_pkg::KERNEL_ID_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  frtr_pkg::bin_cmd_t        cmd,
  input  logic [KERNEL_ID_BITS-1:0] load_kernel,
  input  frtr_pkg::timer_t          timeout_reload,
  input  logic [KERNEL_ID_BITS-1:0] resp_kernel,
  input  frtr_pkg::slot_t           active_slot,
  output logic [KERNEL_ID_BITS-1:0] active_kernel,
  output frtr_pkg::bin_status_t     status
);

  logic [frtr_pkg::SLOT_COUNT-1:0] slot_busy;
  logic [KERNEL_ID_BITS-1:0]       slot_kernel [frtr_pkg::SLOT_COUNT];
  frtr_pkg::timer_t                slot_timer  [frtr_pkg::SLOT_COUNT];

  // First busy bin matching the response, and first busy bin whose timer ran out.
  always_comb begin
    status = '0;
    for (int i = frtr_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_busy[i] && slot_kernel[i] == resp_kernel) begin
        status.match_hit  = 1'b1;
        status.match_slot = frtr_pkg::slot_t'(i);
      end
      if (slot_busy[i] && slot_timer[i] == '0) begin
        status.expire_hit  = 1'b1;
        status.expire_slot = frtr_pkg::slot_t'(i);
      end
    end
  end

  // Kernel id of the bin whose payload flit is being sent.
  always_comb begin
    active_kernel = '0;
    for (int i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
      if (active_slot == frtr_pkg::slot_t'(i)) begin
        active_kernel = slot_kernel[i];
      end
    end
  end

  // Per-bin updates; the control logic never frees and loads in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
      for (int i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
        slot_kernel[i] <= '0;
        slot_timer[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
        if (cmd.free && cmd.free_slot == frtr_pkg::slot_t'(i)) begin
          slot_busy[i] <= 1'b0;
        end
        if (cmd.load && cmd.load_slot == frtr_pkg::slot_t'(i)) begin
          slot_busy[i]   <= 1'b1;
          slot_kernel[i] <= load_kernel;
          slot_timer[i]  <= timeout_reload;
        end else if (cmd.retry && cmd.retry_slot == frtr_pkg::slot_t'(i)) begin
          slot_timer[i] <= timeout_reload;
        end else if (cmd.tick && slot_busy[i] && slot_timer[i] != '0) begin
          slot_timer[i] <= slot_timer[i] - frtr_pkg::timer_t'(1);
        end
      end
    end
  end

endmodule

>>> rtl/fetch_request_tracker_with_retry.sv
// Top level of the fetch request tracker: input register, decision logic, result register.
//
// Channel   Direction  Handshake                      Payload
// input     in         start & !busy                  resp_*, req_*, out_ready, upd_ready
// result    out        done (one-cycle strobe)        net_*, upd_*
// config    in         cfg_valid & cfg_ready          cfg_index, cfg_data
//
// An accepted item is registered, decided in the next cycle and its result shows
// on done from the result register. A new item is taken every cycle while busy is low.
// The three-bin compare and the timer countdown sit between the input register
// and the result register. busy is high during reset and the cycle after it.
// Synchronous reset clears all bins and the pending payload. The receiver
// cannot stall; cfg_ready is always high.
module fetch_request_tracker_with_retry #(
  parameter int KERNEL_ID_BITS = frtr_pkg::KERNEL_ID_BITS_DEFAULT,
  parameter int ADDR_BITS      = frtr_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel.
  input  logic                        start,
  output logic                        busy,
  input  logic                        resp_valid,
  input  logic [ADDR_BITS-1:0]        resp_ip,
  input  logic [KERNEL_ID_BITS-1:0]   resp_kernel,
  input  logic                        req_valid,
  input  logic [1:0]                  req_bin,
  input  logic [KERNEL_ID_BITS-1:0]   req_kernel,
  input  logic                        out_ready,
  input  logic                        upd_ready,
  // Result channel.
  output logic                        done,
  output logic                        net_valid,
  output logic                        net_is_payload,
  output logic [KERNEL_ID_BITS-1:0]   net_kernel,
  output frtr_pkg::server_t           net_server,
  output logic                        upd_valid,
  output logic [1:0]                  upd_bin,
  output logic [KERNEL_ID_BITS-1:0]   upd_kernel,
  output logic [ADDR_BITS-1:0]        upd_ip,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  frtr_pkg::cfg_index_t        cfg_index,
  input  frtr_pkg::server_t           cfg_data
);

  // Configuration registers.
  frtr_pkg::server_t server_address;
  frtr_pkg::timer_t  timeout_reload;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_address <= frtr_pkg::SERVER_RESET;
      timeout_reload <= frtr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frtr_pkg::CFG_SERVER_ADDRESS: server_address <= cfg_data;
        frtr_pkg::CFG_TIMEOUT_RELOAD: timeout_reload <= cfg_data[frtr_pkg::TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Busy covers reset and the first cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register: one item per start transfer.
  logic                      in_valid;
  logic                      in_resp_valid;
  logic [ADDR_BITS-1:0]      in_resp_ip;
  logic [KERNEL_ID_BITS-1:0] in_resp_kernel;
  logic                      in_req_valid;
  logic [1:0]                in_req_bin;
  logic [KERNEL_ID_BITS-1:0] in_req_kernel;
  logic                      in_out_ready;
  logic                      in_upd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_resp_valid  <= resp_valid;
      in_resp_ip     <= resp_ip;
      in_resp_kernel <= resp_kernel;
      in_req_valid   <= req_valid;
      in_req_bin     <= req_bin;
      in_req_kernel  <= req_kernel;
      in_out_ready   <= out_ready;
      in_upd_ready   <= upd_ready;
    end
  end

  // Header/payload phase of the outgoing fetch.
  logic            payload_pending;
  logic            payload_pending_next;
  frtr_pkg::slot_t active_slot;
  frtr_pkg::slot_t active_slot_next;

  frtr_pkg::bin_cmd_t        cmd;
  frtr_pkg::bin_status_t     status;
  logic [KERNEL_ID_BITS-1:0] active_kernel;

  frtr_bins #(
    .KERNEL_ID_BITS(KERNEL_ID_BITS)
  ) u_bins (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .load_kernel    (in_req_kernel),
    .timeout_reload (timeout_reload),
    .resp_kernel    (in_resp_kernel),
    .active_slot    (active_slot),
    .active_kernel  (active_kernel),
    .status         (status)
  );

  // Result values computed from the registered item.
  logic                      net_valid_next;
  logic                      net_is_payload_next;
  logic [KERNEL_ID_BITS-1:0] net_kernel_next;
  logic                      upd_valid_next;
  logic [1:0]                upd_bin_next;
  logic [KERNEL_ID_BITS-1:0] upd_kernel_next;
  logic [ADDR_BITS-1:0]      upd_ip_next;

  logic resp_take;
  logic payload_now;
  logic req_take;

  assign resp_take   = in_resp_valid && in_upd_ready;
  assign payload_now = payload_pending && in_out_ready;
  assign req_take    = in_req_valid && in_req_bin != '0 && in_out_ready && !payload_pending;

  // Priority: response, pending payload, new request, retry, countdown.
  always_comb begin
    cmd                  = '0;
    payload_pending_next = payload_pending;
    active_slot_next     = active_slot;
    net_valid_next       = 1'b0;
    net_is_payload_next  = 1'b0;
    net_kernel_next      = '0;
    upd_valid_next       = 1'b0;
    upd_bin_next         = '0;
    upd_kernel_next      = '0;
    upd_ip_next          = '0;
    if (in_valid) begin
      priority if (resp_take) begin
        if (payload_now) begin
          net_valid_next       = 1'b1;
          net_is_payload_next  = 1'b1;
          net_kernel_next      = active_kernel;
          payload_pending_next = 1'b0;
        end
        if (status.match_hit) begin
          cmd.free        = 1'b1;
          cmd.free_slot   = status.match_slot;
          upd_valid_next  = 1'b1;
          upd_bin_next    = status.match_slot + 2'd1;
          upd_kernel_next = in_resp_kernel;
          upd_ip_next     = in_resp_ip;
        end
      end else if (payload_now) begin
        net_valid_next       = 1'b1;
        net_is_payload_next  = 1'b1;
        net_kernel_next      = active_kernel;
        payload_pending_next = 1'b0;
      end else if (req_take) begin
        cmd.load             = 1'b1;
        cmd.load_slot        = in_req_bin - 2'd1;
        active_slot_next     = in_req_bin - 2'd1;
        net_valid_next       = 1'b1;
        payload_pending_next = 1'b1;
      end else if (!payload_pending && in_out_ready && status.expire_hit) begin
        cmd.retry            = 1'b1;
        cmd.retry_slot       = status.expire_slot;
        active_slot_next     = status.expire_slot;
        net_valid_next       = 1'b1;
        payload_pending_next = 1'b1;
      end else begin
        cmd.tick = 1'b1;
      end
    end
  end

  // Phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_pending <= 1'b0;
      active_slot     <= '0;
    end else begin
      payload_pending <= payload_pending_next;
      active_slot     <= active_slot_next;
    end
  end

  // Result register: one strobe per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    net_valid      <= net_valid_next;
    net_is_payload <= net_is_payload_next;
    net_kernel     <= net_kernel_next;
    net_server     <= net_valid_next ? server_address : '0;
    upd_valid      <= upd_valid_next;
    upd_bin        <= upd_bin_next;
    upd_kernel     <= upd_kernel_next;
    upd_ip         <= upd_ip_next;
  end

  // A header transfer always leaves a payload pending behind it.
  assert property (@(posedge clk) disable iff (rst)
    (done && net_valid && !net_is_payload) |-> payload_pending)
    else $error("header sent without a pending payload");

  // A payload transfer clears the pending payload.
  assert property (@(posedge clk) disable iff (rst)
    (done && net_valid && net_is_payload) |-> !payload_pending)
    else $error("payload sent but still pending");

  // An update always names a real bin.
  assert property (@(posedge clk) disable iff (rst)
    (done && upd_valid) |-> (upd_bin != 2'd0))
    else $error("update reports bin zero");

  // Nothing is reported between items.
  assert property (@(posedge clk) disable iff (rst)
    !done |-> (!net_valid && !upd_valid))
    else $error("result fields set without a strobe");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the fetch request tracker: driver, monitor and cycle predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW = frtr_pkg::KERNEL_ID_BITS_DEFAULT;
  localparam int AW = frtr_pkg::ADDR_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;

  // One offered cycle of inputs.
  typedef struct packed {
    logic          resp_valid;
    logic [AW-1:0] resp_ip;
    logic [KW-1:0] resp_kernel;
    logic          req_valid;
    logic [1:0]    req_bin;
    logic [KW-1:0] req_kernel;
    logic          out_ready;
    logic          upd_ready;
  } cycle_in_t;

  // What the block reports for one cycle.
  typedef struct packed {
    logic              net_valid;
    logic              net_is_payload;
    logic [KW-1:0]     net_kernel;
    frtr_pkg::server_t net_server;
    logic              upd_valid;
    logic [1:0]        upd_bin;
    logic [KW-1:0]     upd_kernel;
    logic [AW-1:0]     upd_ip;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          start = 1'b0;
  logic          busy;
  logic          resp_valid = 1'b0;
  logic [AW-1:0] resp_ip = '0;
  logic [KW-1:0] resp_kernel = '0;
  logic          req_valid = 1'b0;
  logic [1:0]    req_bin = 2'd1;
  logic [KW-1:0] req_kernel = '0;
  logic          out_ready = 1'b0;
  logic          upd_ready = 1'b0;

  logic              done;
  logic              net_valid;
  logic              net_is_payload;
  logic [KW-1:0]     net_kernel;
  frtr_pkg::server_t net_server;
  logic              upd_valid;
  logic [1:0]        upd_bin;
  logic [KW-1:0]     upd_kernel;
  logic [AW-1:0]     upd_ip;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  frtr_pkg::cfg_index_t cfg_index = frtr_pkg::CFG_SERVER_ADDRESS;
  frtr_pkg::server_t    cfg_data = '0;

  fetch_request_tracker_with_retry #(
    .KERNEL_ID_BITS(KW),
    .ADDR_BITS(AW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .resp_valid(resp_valid),
    .resp_ip(resp_ip),
    .resp_kernel(resp_kernel),
    .req_valid(req_valid),
    .req_bin(req_bin),
    .req_kernel(req_kernel),
    .out_ready(out_ready),
    .upd_ready(upd_ready),
    .done(done),
    .net_valid(net_valid),
    .net_is_payload(net_is_payload),
    .net_kernel(net_kernel),
    .net_server(net_server),
    .upd_valid(upd_valid),
    .upd_bin(upd_bin),
    .upd_kernel(upd_kernel),
    .upd_ip(upd_ip),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cycle_in_t        cycles_to_send[$];
  outcome_t         pending_outcomes[$];
  logic [KW-1:0]    recent_kernels[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               gap_left = 0;
  bit               no_gaps = 1'b0;

  // Tracker state as predicted, plus its registers.
  logic              trk_pending;
  frtr_pkg::slot_t   trk_slot;
  logic              trk_busy[frtr_pkg::SLOT_COUNT];
  logic [KW-1:0]     trk_kernel[frtr_pkg::SLOT_COUNT];
  frtr_pkg::timer_t  trk_timer[frtr_pkg::SLOT_COUNT];
  frtr_pkg::server_t trk_server;
  frtr_pkg::timer_t  trk_reload;

  // Reports one mismatch; printing is capped so a broken block cannot flood the log.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // Advances the predicted tracker by one cycle and returns what it should report.
  function automatic outcome_t track_cycle(input cycle_in_t c);
    outcome_t o;
    logic     payload_now;
    logic     handled;
    int       i;
    o = '0;
    handled = 1'b0;
    payload_now = trk_pending && c.out_ready;
    if (c.resp_valid && c.upd_ready) begin
      // A response wins; a pending payload may still leave in the same cycle.
      if (payload_now) begin
        o.net_valid = 1'b1;
        o.net_is_payload = 1'b1;
        o.net_kernel = trk_kernel[trk_slot];
        trk_pending = 1'b0;
      end
      for (i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
        if (!handled && trk_busy[i] && trk_kernel[i] == c.resp_kernel) begin
          o.upd_valid = 1'b1;
          o.upd_bin = frtr_pkg::slot_t'(i + 1);
          o.upd_kernel = c.resp_kernel;
          o.upd_ip = c.resp_ip;
          trk_busy[i] = 1'b0;
          handled = 1'b1;
        end
      end
    end else if (payload_now) begin
      o.net_valid = 1'b1;
      o.net_is_payload = 1'b1;
      o.net_kernel = trk_kernel[trk_slot];
      trk_pending = 1'b0;
    end else if (c.req_valid && c.req_bin != 2'd0 && c.out_ready && !trk_pending) begin
      // New request: take the bin, even if busy, and send the header.
      i = int'(c.req_bin) - 1;
      trk_busy[i] = 1'b1;
      trk_kernel[i] = c.req_kernel;
      trk_timer[i] = trk_reload;
      trk_slot = frtr_pkg::slot_t'(i);
      o.net_valid = 1'b1;
      trk_pending = 1'b1;
    end else begin
      // Retry the first expired bin, otherwise let the timers run down.
      if (!trk_pending && c.out_ready) begin
        for (i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
          if (!handled && trk_busy[i] && trk_timer[i] == '0) begin
            trk_slot = frtr_pkg::slot_t'(i);
            trk_timer[i] = trk_reload;
            o.net_valid = 1'b1;
            trk_pending = 1'b1;
            handled = 1'b1;
          end
        end
      end
      if (!handled) begin
        for (i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
          if (trk_busy[i] && trk_timer[i] != '0)
            trk_timer[i] = trk_timer[i] - frtr_pkg::timer_t'(1);
        end
      end
    end
    if (o.net_valid)
      o.net_server = trk_server;
    return o;
  endfunction

  function automatic cycle_in_t mk_cycle(input logic rv, input logic [AW-1:0] ip,
                                         input logic [KW-1:0] rk, input logic qv,
                                         input logic [1:0] bin, input logic [KW-1:0] qk,
                                         input logic ordy, input logic urdy);
    cycle_in_t c;
    c.resp_valid = rv;
    c.resp_ip = ip;
    c.resp_kernel = rk;
    c.req_valid = qv;
    c.req_bin = bin;
    c.req_kernel = qk;
    c.out_ready = ordy;
    c.upd_ready = urdy;
    return c;
  endfunction

  // Mostly a small pool so that several bins share ids; sometimes the full range.
  function automatic logic [KW-1:0] pick_kernel();
    if ($urandom_range(0, 99) < 60)
      return KW'($urandom_range(0, 7));
    return KW'($urandom_range(0, (1 << KW) - 1));
  endfunction

  // Idle length after an item: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60)
      return 0;
    if (roll < 88)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random cycles: requests, responses aimed at recent kernel ids, idle cycles and noise.
  task automatic queue_random(input int n);
    cycle_in_t c;
    int        roll;
    repeat (n) begin
      c.resp_valid = ($urandom_range(0, 9) == 0);
      c.resp_ip = AW'($urandom);
      c.resp_kernel = pick_kernel();
      c.req_valid = 1'b0;
      c.req_bin = 2'($urandom_range(1, 3));
      c.req_kernel = pick_kernel();
      c.out_ready = ($urandom_range(0, 99) < 85);
      c.upd_ready = ($urandom_range(0, 99) < 85);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        c.req_valid = 1'b1;
        c.out_ready = ($urandom_range(0, 99) < 92);
        recent_kernels.push_back(c.req_kernel);
        if (recent_kernels.size() > 8)
          void'(recent_kernels.pop_front());
      end else if (roll < 55) begin
        c.resp_valid = 1'b1;
        if (recent_kernels.size() != 0 && $urandom_range(0, 99) < 75)
          c.resp_kernel = recent_kernels[$urandom_range(0, recent_kernels.size() - 1)];
      end else if (roll >= 90) begin
        c.resp_valid = 1'($urandom_range(0, 1));
        c.req_valid = 1'($urandom_range(0, 1));
        c.req_bin = 2'($urandom_range(0, 3));
        c.out_ready = 1'($urandom_range(0, 1));
        c.upd_ready = 1'($urandom_range(0, 1));
      end
      cycles_to_send.push_back(c);
    end
  endtask

  // Waits until every queued cycle went in and every outcome came back.
  task automatic settle();
    do
      @(negedge clk);
    while (cycles_to_send.size() != 0 || start || pending_outcomes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input frtr_pkg::cfg_index_t idx, input frtr_pkg::server_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do
      @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input frtr_pkg::server_t srv, input frtr_pkg::timer_t reload);
    settle();
    write_reg(frtr_pkg::CFG_SERVER_ADDRESS, srv);
    write_reg(frtr_pkg::CFG_TIMEOUT_RELOAD, frtr_pkg::server_t'(reload));
  endtask

  // One random phase; the sender pauses halfway until all outcomes are back.
  task automatic run_phase(input frtr_pkg::server_t srv, input frtr_pkg::timer_t reload,
                           input int n, input bit steady);
    load_settings(srv, reload);
    no_gaps = steady;
    queue_random(n / 2);
    settle();
    queue_random(n - n / 2);
  endtask

  // Driver: offers queued cycles, holds each until its transfer, then idles at random.
  always @(posedge clk) begin : driver
    cycle_in_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (cycles_to_send.size() != 0) begin
        nxt = cycles_to_send.pop_front();
        resp_valid <= nxt.resp_valid;
        resp_ip <= nxt.resp_ip;
        resp_kernel <= nxt.resp_kernel;
        req_valid <= nxt.req_valid;
        req_bin <= nxt.req_bin;
        req_kernel <= nxt.req_kernel;
        out_ready <= nxt.out_ready;
        upd_ready <= nxt.upd_ready;
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: follows register writes, predicts each accepted cycle, checks each outcome.
  always @(posedge clk) begin : monitor
    cycle_in_t seen;
    outcome_t  got;
    outcome_t  want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == frtr_pkg::CFG_SERVER_ADDRESS)
          trk_server = cfg_data;
        else if (cfg_index == frtr_pkg::CFG_TIMEOUT_RELOAD)
          trk_reload = frtr_pkg::timer_t'(cfg_data);
      end
      if (start && !busy) begin
        seen.resp_valid = resp_valid;
        seen.resp_ip = resp_ip;
        seen.resp_kernel = resp_kernel;
        seen.req_valid = req_valid;
        seen.req_bin = req_bin;
        seen.req_kernel = req_kernel;
        seen.out_ready = out_ready;
        seen.upd_ready = upd_ready;
        pending_outcomes.push_back(track_cycle(seen));
      end
      if (done) begin
        got.net_valid = net_valid;
        got.net_is_payload = net_is_payload;
        got.net_kernel = net_kernel;
        got.net_server = net_server;
        got.upd_valid = upd_valid;
        got.upd_bin = upd_bin;
        got.upd_kernel = upd_kernel;
        got.upd_ip = upd_ip;
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("outcome with nothing pending", 32'(got.net_valid), 32'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.net_valid !== want.net_valid)
            flag_mismatch("net_valid", 32'(got.net_valid), 32'(want.net_valid));
          if (got.net_is_payload !== want.net_is_payload)
            flag_mismatch("net_is_payload", 32'(got.net_is_payload),
                          32'(want.net_is_payload));
          if (got.net_kernel !== want.net_kernel)
            flag_mismatch("net_kernel", 32'(got.net_kernel), 32'(want.net_kernel));
          if (got.net_server !== want.net_server)
            flag_mismatch("net_server", got.net_server, want.net_server);
          if (got.upd_valid !== want.upd_valid)
            flag_mismatch("upd_valid", 32'(got.upd_valid), 32'(want.upd_valid));
          if (got.upd_bin !== want.upd_bin)
            flag_mismatch("upd_bin", 32'(got.upd_bin), 32'(want.upd_bin));
          if (got.upd_kernel !== want.upd_kernel)
            flag_mismatch("upd_kernel", 32'(got.upd_kernel), 32'(want.upd_kernel));
          if (got.upd_ip !== want.upd_ip)
            flag_mismatch("upd_ip", 32'(got.upd_ip), 32'(want.upd_ip));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sequence of the run: reset, directed cycles, then random phases under varied settings.
  initial begin : sequencer
    int i;
    trk_pending = 1'b0;
    trk_slot = '0;
    for (i = 0; i < frtr_pkg::SLOT_COUNT; i++) begin
      trk_busy[i] = 1'b0;
      trk_kernel[i] = '0;
      trk_timer[i] = '0;
    end
    trk_server = frtr_pkg::SERVER_RESET;
    trk_reload = frtr_pkg::TIMEOUT_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed cycles under the reset settings.
    // All stalled.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b0, 1'b0));
    // Header, bin 1.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd1, 8'hFF, 1'b1, 1'b1));
    // Payload stalled.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd2, 8'h00, 1'b0, 1'b1));
    // Payload beats request.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd2, 8'h00, 1'b1, 1'b1));
    // Header, bin 2.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd2, 8'h00, 1'b1, 1'b1));
    // Match plus payload.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Bin zero request.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd0, 8'h55, 1'b1, 1'b1));
    // Update held.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'h1234_5678, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b0));
    // Match bin 2.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Header, bin 3.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd3, 8'hAA, 1'b1, 1'b1));
    // Payload.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Overwrite busy bin.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd3, 8'h55, 1'b1, 1'b1));
    // Payload.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Dropped.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'hA5A5_A5A5, 8'hAA, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Match bin 3.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'h5A5A_5A5A, 8'h55, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd1, 8'h07, 1'b1, 1'b1));
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Same id, bin 2.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd2, 8'h07, 1'b1, 1'b1));
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // First bin wins.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'h0000_0001, 8'h07, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Then bin 2.
    cycles_to_send.push_back(mk_cycle(1'b1, 32'h8000_0000, 8'h07, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));

    // Zero reload: a bin is sent again on the next idle cycle.
    load_settings(32'hFFFF_FFFF, 16'd0);
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b1, 2'd1, 8'h80, 1'b1, 1'b1));
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Retry header.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    // Retry payload.
    cycles_to_send.push_back(mk_cycle(1'b0, 32'h0, 8'h00, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));
    cycles_to_send.push_back(mk_cycle(1'b1, 32'hCAFE_0001, 8'h80, 1'b0, 2'd1, 8'h00, 1'b1, 1'b1));

    run_phase(frtr_pkg::server_t'($urandom), 16'd0, 70, 1'b0);
    run_phase(frtr_pkg::server_t'($urandom), 16'd1, 70, 1'b1);
    run_phase(32'h0, 16'd3, 70, 1'b0);
    run_phase(frtr_pkg::server_t'($urandom), frtr_pkg::timer_t'($urandom_range(2, 12)), 70,
              1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 60, 1'b0);
    run_phase(frtr_pkg::server_t'($urandom), frtr_pkg::timer_t'($urandom_range(0, 6)), 90,
              1'b0);

    settle();
    if (pending_outcomes.size() != 0)
      flag_mismatch("outcomes never seen", 32'd0, 32'(pending_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
